// ===== rtl/rlf_pkg.sv =====
// Shared constants and codes for the RGB LED linear fader.
`default_nettype none
package rlf_pkg;

  localparam int unsigned LVL_W  = 8;   // color level width
  localparam int unsigned DUTY_W = 16;  // duty, period and full-scale width
  localparam int unsigned CNT_W  = 4;   // divider step counter width

  // Operation codes of an input item.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Register select, taken from paddr bit 2.
  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic REG_FULL_SCALE  = 1'b1;

  localparam logic [DUTY_W-1:0] TICK_PERIOD_RST = 16'd10;
  localparam logic [DUTY_W-1:0] FULL_SCALE_RST  = 16'd255;

  // Divisor that maps a level onto the duty range.
  localparam logic [DUTY_W:0] LEVEL_MAX = 17'd255;

  // Last step index of each divider run.
  localparam logic [CNT_W-1:0] LDIV_LAST = 4'd7;
  localparam logic [CNT_W-1:0] DDIV_LAST = 4'd15;

endpackage
`default_nettype wire

// ===== rtl/rgb_led_linear_fader_unit.sv =====
// Top level of the RGB LED linear fader with its bit-serial divider.
`default_nettype none
// A set color transfer stores the target and works out the step count; a tick transfer yields
// one result. All levels and duties go through one shared restoring divider that produces one
// quotient bit per cycle: per channel 8 steps for the rounded level, run only while a fade
// is active, and 16 steps for the duty scaling. A new item is taken once the previous one is
// done; a finished result waits in the output register and only holds the block when a second
// result is ready before it is taken.
module rgb_led_linear_fader_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  target_red_i,
  input  logic [7:0]  target_green_i,
  input  logic [7:0]  target_blue_i,
  input  logic [15:0] fade_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] red_duty_o,
  output logic [15:0] green_duty_o,
  output logic [15:0] blue_duty_o,
  output logic        fading_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_DIV,
    ST_LVL_MUL,
    ST_LVL_DIV,
    ST_DUTY_MUL,
    ST_DUTY_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [15:0] tick_period_q, full_scale_q;
  logic [7:0]  base_q [3];
  logic [7:0]  goal_q [3];
  logic [15:0] step_total_q, step_index_q;
  logic [15:0] dty_q [3];
  logic [1:0]  ch_q;
  logic [3:0]  cnt_q;
  logic [16:0] rem_q, dvs_q;
  logic [15:0] shf_q;
  logic        out_valid_q, fading_q;
  logic [15:0] red_q, green_q, blue_q;

  // Divider step.
  logic [18:0] diff;
  logic        ge;
  logic [16:0] rem_d;
  logic [15:0] shf_d;

  always_comb begin
    diff  = {1'b0, rem_q, shf_q[15]} - {2'b00, dvs_q};
    ge    = ~diff[18];
    rem_d = ge ? diff[16:0] : {rem_q[15:0], shf_q[15]};
    shf_d = {shf_q[14:0], ge};
  end

  // Channel datapath.
  logic        active, up;
  logic [7:0]  b_sel, g_sel, mag, level;
  logic [23:0] prod, duty_prod;
  logic [24:0] num;
  logic [15:0] per, fade_t;

  always_comb begin
    case (ch_q)
      2'd0: begin
        b_sel = base_q[0];
        g_sel = goal_q[0];
      end
      2'd1: begin
        b_sel = base_q[1];
        g_sel = goal_q[1];
      end
      default: begin
        b_sel = base_q[2];
        g_sel = goal_q[2];
      end
    endcase
    active = (step_index_q != 16'd0) && (step_total_q != 16'd0);
    up     = g_sel >= b_sel;
    mag    = up ? (g_sel - b_sel) : (b_sel - g_sel);
    prod   = {8'd0, step_index_q} * {16'd0, mag};
    // Rounded quotient with halves away from zero: (2*k*mag + n) / (2*n).
    num    = {prod, 1'b0} + {9'd0, step_total_q};
    if (!active) begin
      level = b_sel;
    end else if (up) begin
      level = b_sel + shf_q[7:0];
    end else begin
      level = b_sel - shf_q[7:0];
    end
    duty_prod = {16'd0, level} * {8'd0, full_scale_q};
    per       = (tick_period_q == 16'd0) ? 16'd1 : tick_period_q;
    fade_t    = (fade_ms_i > per) ? fade_ms_i : per;
  end

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_period_q <= rlf_pkg::TICK_PERIOD_RST;
      full_scale_q  <= rlf_pkg::FULL_SCALE_RST;
      for (int i = 0; i < 3; i++) begin
        base_q[i] <= 8'd0;
        goal_q[i] <= 8'd0;
        dty_q[i]  <= 16'd0;
      end
      step_total_q <= 16'd0;
      step_index_q <= 16'd0;
      ch_q         <= 2'd0;
      cnt_q        <= 4'd0;
      rem_q        <= 17'd0;
      dvs_q        <= 17'd0;
      shf_q        <= 16'd0;
      out_valid_q  <= 1'b0;
      fading_q     <= 1'b0;
      red_q        <= 16'd0;
      green_q      <= 16'd0;
      blue_q       <= 16'd0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          rlf_pkg::REG_TICK_PERIOD: tick_period_q <= pwdata[15:0];
          default:                  full_scale_q  <= pwdata[15:0];
        endcase
      end

      // In the done state the output register is reloaded instead.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (operation_i == rlf_pkg::OP_SET) begin
              goal_q[0] <= target_red_i;
              goal_q[1] <= target_green_i;
              goal_q[2] <= target_blue_i;
              rem_q     <= 17'd0;
              shf_q     <= fade_t;
              dvs_q     <= {1'b0, per};
              cnt_q     <= rlf_pkg::DDIV_LAST;
              state_q   <= ST_SET_DIV;
            end else begin
              ch_q    <= 2'd0;
              state_q <= ST_LVL_MUL;
            end
          end
        end
        ST_SET_DIV: begin
          rem_q <= rem_d;
          shf_q <= shf_d;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            step_total_q <= shf_d;
            step_index_q <= 16'd1;
            state_q      <= ST_IDLE;
          end
        end
        ST_LVL_MUL: begin
          if (active) begin
            rem_q   <= num[24:8];
            shf_q   <= {num[7:0], 8'd0};
            dvs_q   <= {step_total_q, 1'b0};
            cnt_q   <= rlf_pkg::LDIV_LAST;
            state_q <= ST_LVL_DIV;
          end else begin
            state_q <= ST_DUTY_MUL;
          end
        end
        ST_LVL_DIV: begin
          rem_q <= rem_d;
          shf_q <= shf_d;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            state_q <= ST_DUTY_MUL;
          end
        end
        ST_DUTY_MUL: begin
          // The top byte of level * full_scale is always below 255.
          rem_q   <= {9'd0, duty_prod[23:16]};
          shf_q   <= duty_prod[15:0];
          dvs_q   <= rlf_pkg::LEVEL_MAX;
          cnt_q   <= rlf_pkg::DDIV_LAST;
          state_q <= ST_DUTY_DIV;
        end
        ST_DUTY_DIV: begin
          rem_q <= rem_d;
          shf_q <= shf_d;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            case (ch_q)
              2'd0:    dty_q[0] <= shf_d;
              2'd1:    dty_q[1] <= shf_d;
              default: dty_q[2] <= shf_d;
            endcase
            if (ch_q == 2'd2) begin
              state_q <= ST_DONE;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= ST_LVL_MUL;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            red_q       <= dty_q[0];
            green_q     <= dty_q[1];
            blue_q      <= dty_q[2];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (active && (step_index_q < step_total_q)) begin
              step_index_q <= step_index_q + 16'd1;
              fading_q     <= 1'b1;
            end else begin
              // The final step settles the base on the goal.
              if (active) begin
                for (int i = 0; i < 3; i++) begin
                  base_q[i] <= goal_q[i];
                end
              end
              step_index_q <= 16'd0;
              fading_q     <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rlf_pkg::REG_TICK_PERIOD: prdata = {16'd0, tick_period_q};
      default:                  prdata = {16'd0, full_scale_q};
    endcase
  end

  assign pready       = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = red_q;
  assign green_duty_o = green_q;
  assign blue_duty_o  = blue_q;
  assign fading_o     = fading_q;

endmodule
`default_nettype wire

// ===== rtl/rlf_checker.sv =====
// Port-level checks of the RGB LED linear fader, bound to its top level.
`default_nettype none
module rlf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        operation_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] red_duty_o,
  input logic [15:0] green_duty_o,
  input logic [15:0] blue_duty_o,
  input logic        fading_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_duty_o) && $stable(green_duty_o)
      && $stable(blue_duty_o) && $stable(fading_o))
    else $error("result payload changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  // A set color transfer never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == rlf_pkg::OP_SET) && !out_valid_o
      |=> !out_valid_o)
    else $error("result after a set color transfer");

endmodule

bind rgb_led_linear_fader_unit rlf_checker u_rlf_checker (.*);
`default_nettype wire
